// ----- design/pairwise_distance_table_top_defines.svh -----
// ----------------------------------------------------------------------------
// pairwise distance table: assertion macros
// concurrent checks used by the top level, empty in synthesis builds
// ----------------------------------------------------------------------------
`ifndef PAIRWISE_DISTANCE_TABLE_TOP_DEFINES_SVH
`define PAIRWISE_DISTANCE_TABLE_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define PDT_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication
`define PDT_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define PDT_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define PDT_ASSERT_NXT(label, clk, rst, ante, cons, msg)
`endif

`endif

// ----- design/pdt_pkg.sv -----
// ----------------------------------------------------------------------------
// pdt_pkg
// types, widths and constants shared by the pairwise distance table
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pdt_pkg;

   localparam int IDX_W   = 12;
   localparam int COUNT_W = 13;
   localparam int COORD_W = 25;
   localparam int DIFF_W  = 25;               // magnitude of a coordinate difference
   localparam int SUM_W   = 52;               // sum of three squared differences
   localparam int ROOT_W  = SUM_W / 2;
   localparam int DIST_W  = 25;

   localparam logic [COUNT_W-1:0] COUNT_RESET     = 13'd4096;
   localparam logic [DIST_W-1:0]  ABSENT_DISTANCE = 25'd999000;
   localparam logic [DIST_W-1:0]  DIST_MAX        = {DIST_W{1'b1}};

   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   localparam logic [1:0] DIM_X = 2'd0;
   localparam logic [1:0] DIM_Y = 2'd1;
   localparam logic [1:0] DIM_Z = 2'd2;

   typedef struct packed {
      logic                      present;
      logic signed [COORD_W-1:0] z;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] x;
   } entry_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ_B,
      ST_CHECK,
      ST_SQUARE,
      ST_SQRT,
      ST_DONE
   } state_type;

   function automatic logic signed [COORD_W-1:0] coord_sel(entry_type e, logic [1:0] dim);
      logic signed [COORD_W-1:0] c;
      case (dim)
         DIM_X:   c = e.x;
         DIM_Y:   c = e.y;
         DIM_Z:   c = e.z;
         default: c = '0;
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

// ----- design/pdt_ram.sv -----
// ----------------------------------------------------------------------------
// pdt_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pdt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- design/pdt_sqacc.sv -----
// ----------------------------------------------------------------------------
// pdt_sqacc
// sum of squared coordinate differences through one shared multiplier
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pdt_sqacc (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   input  wire pdt_pkg::entry_type       a_word,
   input  wire pdt_pkg::entry_type       b_word,
   output logic                          done,
   output logic [pdt_pkg::SUM_W-1:0]     sum
);

   pdt_pkg::entry_type              a_ff;
   pdt_pkg::entry_type              b_ff;
   logic [1:0]                      dim_ff;
   logic                            phase_ff;     // 0 difference, 1 square
   logic                            busy_ff;
   logic                            done_ff;
   logic [pdt_pkg::DIFF_W-1:0]      diff_ff;
   logic [pdt_pkg::SUM_W-1:0]       sum_ff;

   logic signed [pdt_pkg::COORD_W:0] diff_s;
   logic [pdt_pkg::COORD_W:0]        diff_mag;
   logic [2*pdt_pkg::DIFF_W-1:0]     prod;

   always_comb begin
      diff_s   = (pdt_pkg::COORD_W+1)'(pdt_pkg::coord_sel(a_ff, dim_ff))
               - (pdt_pkg::COORD_W+1)'(pdt_pkg::coord_sel(b_ff, dim_ff));
      diff_mag = diff_s[pdt_pkg::COORD_W] ? 26'(-diff_s) : 26'(diff_s);
      prod     = diff_ff * diff_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         phase_ff <= 1'b0;
         dim_ff   <= pdt_pkg::DIM_X;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff  <= 1'b1;
            phase_ff <= 1'b0;
            dim_ff   <= pdt_pkg::DIM_X;
         end else if (busy_ff) begin
            phase_ff <= ~phase_ff;
            if (phase_ff) begin
               if (dim_ff == pdt_pkg::DIM_Z) begin
                  busy_ff <= 1'b0;
                  done_ff <= 1'b1;
               end else begin
                  dim_ff <= dim_ff + 2'd1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         a_ff   <= a_word;
         b_ff   <= b_word;
         sum_ff <= '0;
      end else if (busy_ff) begin
         if (!phase_ff) begin
            diff_ff <= diff_mag[pdt_pkg::DIFF_W-1:0];
         end else begin
            sum_ff <= sum_ff + pdt_pkg::SUM_W'(prod);
         end
      end
   end

   assign done = done_ff;
   assign sum  = sum_ff;

endmodule

`default_nettype wire

// ----- design/pdt_isqrt.sv -----
// ----------------------------------------------------------------------------
// pdt_isqrt
// floor integer square root, one result bit per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pdt_isqrt (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic [pdt_pkg::SUM_W-1:0] radicand,
   output logic                           done,
   output logic [pdt_pkg::ROOT_W-1:0]     root
);

   localparam int REM_W = pdt_pkg::ROOT_W + 1;
   localparam int CNT_W = $clog2(pdt_pkg::ROOT_W);

   logic [pdt_pkg::SUM_W-1:0]  rad_ff;
   logic [REM_W-1:0]           rem_ff;
   logic [pdt_pkg::ROOT_W-1:0] root_ff;
   logic [CNT_W-1:0]           cnt_ff;
   logic                       busy_ff;
   logic                       done_ff;

   logic [REM_W+1:0] rem_sh;
   logic [REM_W+1:0] trial;
   logic             fits;

   always_comb begin
      rem_sh = {rem_ff, rad_ff[pdt_pkg::SUM_W-1 -: 2]};
      trial  = (REM_W+2)'({root_ff, 2'b01});
      fits   = rem_sh >= trial;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(pdt_pkg::ROOT_W - 1);
         end else if (busy_ff) begin
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               cnt_ff <= cnt_ff - 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rad_ff  <= radicand;
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (busy_ff) begin
         rad_ff <= {rad_ff[pdt_pkg::SUM_W-3:0], 2'b00};
         if (fits) begin
            rem_ff  <= REM_W'(rem_sh - trial);
            root_ff <= {root_ff[pdt_pkg::ROOT_W-2:0], 1'b1};
         end else begin
            rem_ff  <= REM_W'(rem_sh);
            root_ff <= {root_ff[pdt_pkg::ROOT_W-2:0], 1'b0};
         end
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

`default_nettype wire

// ----- design/pairwise_distance_table_top.sv -----
// ----------------------------------------------------------------------------
// pairwise_distance_table_top
// coordinate table with on-the-fly euclidean distance between two entries
// ----------------------------------------------------------------------------
//  channel  direction  beat contents
//  req_     in         kind, index_a, index_b, coord_x/y/z, present
//  rsp_     out        distance, in_range (one beat per query, none per load)
//  csr_     in         residue_count write
//
//  after reset a clearing pass zeroes the table, no request beat is taken
//  meanwhile; a load is written directly from idle, a query out of range or
//  on equal indices goes straight to done, one on an absent entry reads both
//  entries first, a full distance also runs the six-step square/accumulate
//  unit and the 26-step square root unit
//  the result register lets the next request in while a response is stalled
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "pairwise_distance_table_top_defines.svh"

module pairwise_distance_table_top #(
   parameter int MAX_RESIDUES = 4096
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // request channel
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic                                req_kind,
   input  wire logic [pdt_pkg::IDX_W-1:0]           req_index_a,
   input  wire logic [pdt_pkg::IDX_W-1:0]           req_index_b,
   input  wire logic signed [pdt_pkg::COORD_W-1:0]  req_coord_x,
   input  wire logic signed [pdt_pkg::COORD_W-1:0]  req_coord_y,
   input  wire logic signed [pdt_pkg::COORD_W-1:0]  req_coord_z,
   input  wire logic                                req_present,
   // response channel
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic [pdt_pkg::DIST_W-1:0]               rsp_distance,
   output logic                                     rsp_in_range,
   // register write
   input  wire logic                                csr_wr_en,
   input  wire logic [pdt_pkg::COUNT_W-1:0]         csr_wr_data
);

   localparam int AW      = $clog2(MAX_RESIDUES);
   localparam int ENTRY_W = $bits(pdt_pkg::entry_type);

   pdt_pkg::state_type state_ff, state_in;

   logic [AW-1:0]                 clr_ff;       // clearing pass address
   logic [pdt_pkg::COUNT_W-1:0]   count_ff;     // residue_count
   logic [pdt_pkg::IDX_W-1:0]     idx_b_ff;
   pdt_pkg::entry_type            a_word_ff;
   logic [pdt_pkg::DIST_W-1:0]    res_dist_ff;
   logic                          res_range_ff;
   logic                          rsp_valid_ff;
   logic [pdt_pkg::DIST_W-1:0]    rsp_distance_ff;
   logic                          rsp_in_range_ff;

   logic                          req_fire;
   logic                          valid_a, valid_b;
   logic                          clr_last;
   logic                          both_present;
   logic                          rsp_free;

   // ram side
   logic                          ram_wr_en;
   logic [AW-1:0]                 ram_wr_addr;
   pdt_pkg::entry_type            ram_wr_data;
   logic                          ram_rd_en;
   logic [AW-1:0]                 ram_rd_addr;
   logic [ENTRY_W-1:0]            ram_rd_raw;
   pdt_pkg::entry_type            ram_rd_word;

   // shared arithmetic units
   logic                          sq_start, sq_done;
   logic [pdt_pkg::SUM_W-1:0]     sq_sum;
   logic                          rt_start, rt_done;
   logic [pdt_pkg::ROOT_W-1:0]    rt_root;
   logic [pdt_pkg::DIST_W-1:0]    dist_sat;
   logic                          rsp_load;

   // index checks, a count above the table depth acts as the depth
   always_comb begin
      req_fire     = req_valid && !req_stall;
      valid_a      = (pdt_pkg::COUNT_W'(req_index_a) < count_ff)
                  && (32'(req_index_a) < MAX_RESIDUES);
      valid_b      = (pdt_pkg::COUNT_W'(req_index_b) < count_ff)
                  && (32'(req_index_b) < MAX_RESIDUES);
      clr_last     = clr_ff == AW'(MAX_RESIDUES - 1);
      ram_rd_word  = pdt_pkg::entry_type'(ram_rd_raw);
      both_present = a_word_ff.present && ram_rd_word.present;
      rsp_free     = !rsp_valid_ff || !rsp_stall;
      dist_sat     = rt_root[pdt_pkg::ROOT_W-1] ? pdt_pkg::DIST_MAX
                                                : rt_root[pdt_pkg::DIST_W-1:0];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pdt_pkg::ST_CLEAR: begin
            if (clr_last) state_in = pdt_pkg::ST_IDLE;
         end
         pdt_pkg::ST_IDLE: begin
            if (req_fire && req_kind == pdt_pkg::KIND_QUERY) begin
               if (!(valid_a && valid_b) || req_index_a == req_index_b) begin
                  state_in = pdt_pkg::ST_DONE;
               end else begin
                  state_in = pdt_pkg::ST_READ_B;
               end
            end
         end
         pdt_pkg::ST_READ_B: state_in = pdt_pkg::ST_CHECK;
         pdt_pkg::ST_CHECK: begin
            state_in = both_present ? pdt_pkg::ST_SQUARE : pdt_pkg::ST_DONE;
         end
         pdt_pkg::ST_SQUARE: begin
            if (sq_done) state_in = pdt_pkg::ST_SQRT;
         end
         pdt_pkg::ST_SQRT: begin
            if (rt_done) state_in = pdt_pkg::ST_DONE;
         end
         pdt_pkg::ST_DONE: begin
            if (rsp_free) state_in = pdt_pkg::ST_IDLE;
         end
         default: state_in = pdt_pkg::ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_stall   = 1'b1;
      ram_wr_en   = 1'b0;
      ram_wr_addr = AW'(req_index_a);
      ram_wr_data = '{present: req_present, z: req_coord_z, y: req_coord_y,
                      x: req_coord_x};
      ram_rd_en   = 1'b0;
      ram_rd_addr = AW'(req_index_a);
      sq_start    = 1'b0;
      rt_start    = 1'b0;
      rsp_load    = 1'b0;
      case (state_ff)
         pdt_pkg::ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_ff;
            ram_wr_data = '0;
         end
         pdt_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            ram_wr_en = req_fire && req_kind == pdt_pkg::KIND_LOAD && valid_a;
            ram_rd_en = req_fire && req_kind == pdt_pkg::KIND_QUERY;
         end
         pdt_pkg::ST_READ_B: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = AW'(idx_b_ff);
         end
         pdt_pkg::ST_CHECK:  sq_start = both_present;
         pdt_pkg::ST_SQUARE: rt_start = sq_done;
         pdt_pkg::ST_SQRT:   ;
         pdt_pkg::ST_DONE:   rsp_load = rsp_free;
         default:            ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pdt_pkg::ST_CLEAR;
         clr_ff       <= '0;
         count_ff     <= pdt_pkg::COUNT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == pdt_pkg::ST_CLEAR) clr_ff <= clr_ff + 1'b1;
         if (csr_wr_en) count_ff <= csr_wr_data;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (state_ff == pdt_pkg::ST_IDLE && req_fire) begin
         idx_b_ff     <= req_index_b;
         res_range_ff <= valid_a && valid_b;
         res_dist_ff  <= '0;        // out of range or same entry
      end
      if (state_ff == pdt_pkg::ST_READ_B) a_word_ff <= ram_rd_word;
      if (state_ff == pdt_pkg::ST_CHECK && !both_present) begin
         res_dist_ff <= pdt_pkg::ABSENT_DISTANCE;
      end
      if (state_ff == pdt_pkg::ST_SQRT && rt_done) res_dist_ff <= dist_sat;
      if (rsp_load) begin
         rsp_distance_ff <= res_dist_ff;
         rsp_in_range_ff <= res_range_ff;
      end
   end

   pdt_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_RESIDUES)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_raw)
   );

   pdt_sqacc u_sqacc (
      .clock  (clock),
      .reset  (reset),
      .start  (sq_start),
      .a_word (a_word_ff),
      .b_word (ram_rd_word),
      .done   (sq_done),
      .sum    (sq_sum)
   );

   pdt_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (rt_start),
      .radicand (sq_sum),
      .done     (rt_done),
      .root     (rt_root)
   );

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_distance = rsp_distance_ff;
   assign rsp_in_range = rsp_in_range_ff;

   // checks
   `PDT_ASSERT_IMP(a_oor_zero, clock, reset, rsp_valid && !rsp_in_range, rsp_distance == '0, "out of range beat with non-zero distance")
   `PDT_ASSERT_IMP(a_sq_state, clock, reset, sq_done, state_ff == pdt_pkg::ST_SQUARE, "square unit finished outside its state")
   `PDT_ASSERT_NXT(a_rt_done, clock, reset, rt_done, state_ff == pdt_pkg::ST_DONE, "root result not taken")
   `PDT_ASSERT_IMP(a_clr_quiet, clock, reset, state_ff == pdt_pkg::ST_CLEAR, !rsp_valid_ff && req_stall, "activity during clearing pass")

endmodule

`default_nettype wire
